@@ rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

@@ rtl/rcpb_pkg.sv @@
// package for the random cycle permutation builder
// constants, command codes and the splitmix64 mixing constants
package rcpb_pkg;
  localparam int unsigned MaxNodesDefault = 4096;
  localparam int unsigned CountW = 13;
  localparam int unsigned ValueW = 12;
  localparam logic [63:0] GoldenGamma = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MixMulA = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MixMulB = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    CMD_SEED = 2'd0,
    CMD_SHUFFLE = 2'd1,
    CMD_READ_SUCC = 2'd2,
    CMD_READ_PERM = 2'd3
  } cmd_t;
endpackage

@@ rtl/random_cycle_permutation_builder_unit.sv @@
// top level of the random cycle permutation builder
// depends on rcpb_pkg, rcpb_ram, rcpb_rng_mod and assert_macros.svh
//
// usage: write cfg_node_count (1..MAX_NODES, 0 acts as 1, larger saturates)
// while idle. send one word on in_* (valid/ready); exactly one word comes back
// on out_*. cmd 0 loads the generator seed, cmd 1 shuffles and links the
// cycle and returns the start node, cmd 2 reads a successor, cmd 3 reads a
// permutation entry. reads before any shuffle or past the count give error.
// a shuffle runs an identity pass over the n nodes, then swaps from the last
// node down to node 1 (each a serial splitmix64 draw with split multiplies
// and a 64-step modulo, two reads and two writes on the permutation ram),
// then a linking pass over the nodes.
// one item is worked on at a time; the result sits in an output register and
// in_ready stays low until that word is taken, so a stalled receiver holds
// off the next input. reset clears control state, the seed and the valid
// flag and sets the count to 4096; the tables are not cleared.
`include "assert_macros.svh"
module random_cycle_permutation_builder_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rcpb_pkg::CountW-1:0] cfg_node_count,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_cmd,
  input  logic [63:0]                 in_seed,
  input  logic [rcpb_pkg::ValueW-1:0] in_index,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rcpb_pkg::ValueW-1:0] out_value,
  output logic                        out_error
);
  import rcpb_pkg::*;

  localparam int unsigned MAX_NODES = MaxNodesDefault;
  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned NW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_INIT, S_DRAW, S_SW_RD, S_SW_WAIT,
    S_SW_WR, S_LK_RD, S_LK_WAIT, S_LK_WR, S_LK_CLOSE, S_PUT
  } st_t;

  st_t st_r;
  logic [CountW-1:0] count_r;
  logic [63:0] rng_r;
  logic tv_r;
  logic [NW-1:0] n_r, i_r;
  logic [AW-1:0] j_r;
  logic [ValueW-1:0] vi_r, first_r, prev_r;
  logic [1:0] cmd_r;
  logic out_valid_r, out_error_r;
  logic [ValueW-1:0] out_value_r;
  logic [NW-1:0] act_n;

  logic p_we, s_we;
  logic [AW-1:0] p_wa, p_ra, s_wa, s_ra;
  logic [ValueW-1:0] p_wd, s_wd, p_rd, s_rd;
  logic [AW-1:0] p_wd_src;

  logic rng_start, rng_done;
  logic [63:0] rng_next;
  logic [NW-1:0] rng_res;

  always_comb begin
    if (count_r == '0) act_n = NW'(1);
    else if (32'(count_r) > MAX_NODES) act_n = NW'(MAX_NODES);
    else act_n = NW'(count_r);
  end

  rcpb_ram #(.WIDTH(ValueW), .DEPTH(MAX_NODES)) u_perm (
    .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  rcpb_ram #(.WIDTH(ValueW), .DEPTH(MAX_NODES)) u_succ (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  rcpb_rng_mod #(.DW(NW)) u_rng (
    .clk(clk), .rst_n(rst_n), .start(rng_start), .divisor(i_r + NW'(1)),
    .state_in(rng_r), .state_out(rng_next), .done(rng_done), .result(rng_res));

  assign in_ready = (st_r == S_IDLE) && !out_valid_r;

  always_comb begin
    p_we = 1'b0;
    p_wa = i_r[AW-1:0];
    p_wd_src = i_r[AW-1:0];
    p_wd = ValueW'(p_wd_src);
    p_ra = in_index[AW-1:0];
    s_we = 1'b0;
    s_wa = prev_r[AW-1:0];
    s_wd = p_rd;
    s_ra = in_index[AW-1:0];
    rng_start = 1'b0;
    unique case (st_r)
      S_INIT: p_we = 1'b1;
      S_DRAW: rng_start = 1'b1;
      S_SW_RD: p_ra = i_r[AW-1:0];
      S_SW_WAIT: p_ra = j_r;
      S_SW_WR: begin
        // vi_r holds perm[i]; p_rd holds perm[j]
        p_we = 1'b1;
        p_wd = p_rd;
      end
      S_PUT: begin
        p_we = 1'b1;
        p_wa = j_r;
        p_wd = vi_r;
      end
      S_LK_RD: p_ra = i_r[AW-1:0];
      S_LK_WAIT: p_ra = i_r[AW-1:0];
      S_LK_WR: s_we = 1'b1;
      S_LK_CLOSE: begin
        // last node points back to the start
        s_we = 1'b1;
        s_wd = first_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      count_r <= CountW'(4096);
      rng_r <= '0;
      tv_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) count_r <= cfg_node_count;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= in_cmd;
            unique case (cmd_t'(in_cmd))
              CMD_SEED: begin
                rng_r <= in_seed;
                out_value_r <= '0;
                out_error_r <= 1'b0;
                out_valid_r <= 1'b1;
              end
              CMD_SHUFFLE: begin
                n_r <= act_n;
                i_r <= '0;
                st_r <= S_INIT;
              end
              default: begin
                if (!tv_r || NW'(in_index) >= act_n) begin
                  out_value_r <= '0;
                  out_error_r <= 1'b1;
                  out_valid_r <= 1'b1;
                end else begin
                  st_r <= S_RD_WAIT;
                end
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          out_value_r <= (cmd_t'(cmd_r) == CMD_READ_SUCC) ? s_rd : p_rd;
          out_error_r <= 1'b0;
          out_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        S_INIT: begin
          if (i_r == n_r - NW'(1)) begin
            if (n_r == NW'(1)) begin
              i_r <= '0;
              st_r <= S_LK_RD;
            end else begin
              st_r <= S_DRAW;
            end
          end else begin
            i_r <= i_r + NW'(1);
          end
        end
        S_DRAW: st_r <= S_SW_RD;
        S_SW_RD: begin
          if (rng_done) begin
            rng_r <= rng_next;
            j_r <= rng_res[AW-1:0];
            st_r <= S_SW_WAIT;
          end
        end
        S_SW_WAIT: begin
          vi_r <= p_rd;
          st_r <= S_SW_WR;
        end
        S_SW_WR: begin
          // perm[j] gets the old perm[i] in the next cycle
          st_r <= S_PUT;
        end
        S_PUT: begin
          if (i_r == NW'(1)) begin
            i_r <= '0;
            st_r <= S_LK_RD;
          end else begin
            i_r <= i_r - NW'(1);
            st_r <= S_DRAW;
          end
        end
        S_LK_RD: st_r <= S_LK_WAIT;
        S_LK_WAIT: begin
          if (i_r == '0) begin
            first_r <= p_rd;
            prev_r <= p_rd;
            if (n_r == NW'(1)) begin
              st_r <= S_LK_WR;
            end else begin
              i_r <= NW'(1);
              st_r <= S_LK_RD;
            end
          end else begin
            st_r <= S_LK_WR;
          end
        end
        S_LK_WR: begin
          prev_r <= p_rd;
          if (n_r == NW'(1)) begin
            tv_r <= 1'b1;
            out_value_r <= first_r;
            out_error_r <= 1'b0;
            out_valid_r <= 1'b1;
            st_r <= S_IDLE;
          end else if (i_r == n_r - NW'(1)) begin
            st_r <= S_LK_CLOSE;
          end else begin
            i_r <= i_r + NW'(1);
            st_r <= S_LK_RD;
          end
        end
        S_LK_CLOSE: begin
          tv_r <= 1'b1;
          out_value_r <= first_r;
          out_error_r <= 1'b0;
          out_valid_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_error = out_error_r;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable(out_value_r) && $stable(out_error_r))
  `ASSERT_IMPLIES(a_busy_no_ready, clk, rst_n, st_r != S_IDLE, !in_ready)
  `ASSERT_IMPLIES(a_j_range, clk, rst_n, st_r == S_SW_WAIT, NW'(j_r) <= i_r)
endmodule

@@ rtl/rcpb_ram.sv @@
// generic single-port-write, single-read ram with registered read
// no dependencies
module rcpb_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/rcpb_rng_mod.sv @@
// splitmix64 draw followed by a bit-serial 64-bit modulo
// depends on rcpb_pkg and assert_macros.svh
`include "assert_macros.svh"
module rcpb_rng_mod #(
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] divisor,
  input  logic [63:0]   state_in,
  output logic [63:0]   state_out,
  output logic          done,
  output logic [DW-1:0] result
);
  import rcpb_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MIX1, S_MUL1, S_MIX2, S_MUL2, S_DIV} st_t;

  st_t st_r;
  logic [63:0] z_r, st_out_r;
  logic [63:0] q_r;
  logic [DW:0] rem_r;
  logic [DW-1:0] div_r;
  logic [6:0] cnt_r;
  logic done_r;
  logic [DW:0] shifted;
  logic [1:0] ms_r;
  logic [63:0] plo_r;
  logic [31:0] cross_r;

  // low 64 bits of the product from three 32x32 partial products, one per cycle
  logic [63:0] mul_k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] prod;
  always_comb begin
    shifted = {rem_r[DW-1:0], q_r[63]};
    mul_k = (st_r == S_MUL1) ? MixMulA : MixMulB;
    mul_a = z_r[31:0];
    mul_b = mul_k[31:0];
    if (ms_r == 2'd1) begin
      mul_b = mul_k[63:32];
    end else if (ms_r == 2'd2) begin
      mul_a = z_r[63:32];
    end
    mul_p = 64'(mul_a) * 64'(mul_b);
    prod = plo_r + {cross_r + mul_p[31:0], 32'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            st_out_r <= state_in + GoldenGamma;
            z_r <= state_in + GoldenGamma;
            div_r <= divisor;
            st_r <= S_MIX1;
          end
        end
        S_MIX1: begin
          z_r <= z_r ^ (z_r >> 30);
          ms_r <= 2'd0;
          st_r <= S_MUL1;
        end
        S_MUL1: begin
          if (ms_r == 2'd0) begin
            plo_r <= mul_p;
          end else if (ms_r == 2'd1) begin
            cross_r <= mul_p[31:0];
          end else begin
            z_r <= prod;
            st_r <= S_MIX2;
          end
          ms_r <= ms_r + 2'd1;
        end
        S_MIX2: begin
          z_r <= z_r ^ (z_r >> 27);
          ms_r <= 2'd0;
          st_r <= S_MUL2;
        end
        S_MUL2: begin
          if (ms_r == 2'd0) begin
            plo_r <= mul_p;
          end else if (ms_r == 2'd1) begin
            cross_r <= mul_p[31:0];
          end else begin
            q_r <= prod ^ (prod >> 31);
            rem_r <= '0;
            cnt_r <= 7'd0;
            st_r <= S_DIV;
          end
          ms_r <= ms_r + 2'd1;
        end
        S_DIV: begin
          if (shifted >= {1'b0, div_r}) begin
            rem_r <= shifted - {1'b0, div_r};
          end else begin
            rem_r <= shifted;
          end
          q_r <= {q_r[62:0], 1'b0};
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            st_r <= S_IDLE;
            done_r <= 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign state_out = st_out_r;
  assign done = done_r;
  assign result = rem_r[DW-1:0];

  `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r)
  `ASSERT_IMPLIES(a_done_idle, clk, rst_n, done_r, st_r == S_IDLE)
  `ASSERT_IMPLIES(a_div_cnt, clk, rst_n, st_r == S_DIV, cnt_r <= 7'd63)
endmodule
